@@ src/sdtlb_pkg.sv @@
// Shared codes, request control struct and controller states of the split TLB.
package sdtlb_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    localparam int TABLE_COUNT = 3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] kind;
        logic       allowed;
    } req_ctrl_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

endpackage

@@ src/sdtlb_ram.sv @@
// Single-port-write, single-port-read row memory with registered read data.
module sdtlb_ram #(
    parameter int DEPTH_BITS = 12,
    parameter int WIDTH      = 351
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [DEPTH_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data,
    input  logic                  wr_en,
    input  logic [DEPTH_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data
);

    logic [WIDTH-1:0] mem [2**DEPTH_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/sdtlb_update.sv @@
// Tag match, translation and row update for one read-modify-write of a row.
module sdtlb_update #(
    parameter int TAG_BITS  = 52,
    parameter int ADDR_BITS = 64,
    parameter int ROW_BITS  = 3 * (1 + 52 + 64)
) (
    input  sdtlb_pkg::req_ctrl_t  ctrl,
    input  logic [ADDR_BITS-1:0]  va,
    input  logic [ADDR_BITS-1:0]  pa,
    input  logic [TAG_BITS-1:0]   vpn,
    input  logic [ROW_BITS-1:0]   rd_row,
    output logic                  hit,
    output logic [ADDR_BITS-1:0]  addr,
    output logic                  wr_en,
    output logic [ROW_BITS-1:0]   wr_row
);
    import sdtlb_pkg::*;

    localparam int EW = 1 + TAG_BITS + ADDR_BITS;

    logic                 match [TABLE_COUNT];
    logic [ADDR_BITS-1:0] offset [TABLE_COUNT];

    always_comb
    begin
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            offset[t] = rd_row[t*EW +: ADDR_BITS];
            match[t]  = rd_row[t*EW + EW - 1]
                        && (rd_row[t*EW + ADDR_BITS +: TAG_BITS] == vpn);
        end
    end

    always_comb
    begin
        wr_row = rd_row;
        wr_en  = 1'b0;
        hit    = 1'b0;
        addr   = '0;
        unique case (ctrl.cmd)
            CMD_LOOKUP:
            begin
                for (int t = 0; t < TABLE_COUNT; t++)
                begin
                    if (ctrl.kind == 2'(t) && match[t])
                    begin
                        hit  = 1'b1;
                        addr = offset[t] + va;
                    end
                end
            end
            CMD_FILL:
            begin
                for (int t = 0; t < TABLE_COUNT; t++)
                begin
                    if (ctrl.kind == 2'(t) && ctrl.allowed)
                    begin
                        wr_en = 1'b1;
                        wr_row[t*EW +: EW] = {1'b1, vpn, pa - va};
                    end
                end
            end
            CMD_FLUSH:
            begin
                // drop the matching entry of every table, keep the rest
                wr_en = 1'b1;
                for (int t = 0; t < TABLE_COUNT; t++)
                begin
                    if (match[t])
                    begin
                        wr_row[t*EW + EW - 1] = 1'b0;
                    end
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

@@ src/split_direct_mapped_tlb.sv @@
// Top level of the split read/write/fetch direct-mapped TLB.
//
// Every command (lookup, fill, flush) is accepted when start is high and busy
// is low, and gives one result: the row is read into a register, then ST_EXEC
// sets done_reg, and done pulses for one cycle with hit and translated_address.
// The three tables share one row per index in a single memory with registered
// read data, so each command is a row read followed by a write back, and no new
// command is taken before its write back. A flush of address zero sweeps one row
// per cycle and reports once the last row is cleared. After reset the same sweep
// clears every row while busy is high. The receiver cannot stall results.
module split_direct_mapped_tlb #(
    parameter int INDEX_BITS = 12,
    parameter int PAGE_BITS  = 12,
    parameter int ADDR_BITS  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [1:0]           access_kind,
    input  logic [ADDR_BITS-1:0] virtual_address,
    input  logic [ADDR_BITS-1:0] physical_address,
    input  logic                 fill_allowed,
    output logic                 done,
    output logic                 hit,
    output logic [ADDR_BITS-1:0] translated_address
);
    import sdtlb_pkg::*;

    localparam int TAG_BITS = ADDR_BITS - PAGE_BITS;
    localparam int EW       = 1 + TAG_BITS + ADDR_BITS;
    localparam int ROW_BITS = TABLE_COUNT * EW;

    state_t                state_reg, state_next;
    logic [INDEX_BITS-1:0] sweep_index_reg, sweep_index_next;
    req_ctrl_t             ctrl_reg;
    logic [ADDR_BITS-1:0]  va_reg, pa_reg;
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;

    logic                  accept;
    logic [INDEX_BITS-1:0] in_index, item_index;
    logic [TAG_BITS+INDEX_BITS-1:0] in_vpn_wide, item_vpn_wide;
    logic [TAG_BITS-1:0]   item_vpn;

    logic                  mem_wr_en;
    logic [INDEX_BITS-1:0] mem_wr_addr;
    logic [ROW_BITS-1:0]   mem_wr_data, mem_rd_data;

    logic                  upd_hit, upd_wr_en;
    logic [ADDR_BITS-1:0]  upd_addr;
    logic [ROW_BITS-1:0]   upd_row;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    // index is the page number modulo the table size, zero-extended if narrower
    assign in_vpn_wide   = {{INDEX_BITS{1'b0}}, virtual_address[ADDR_BITS-1:PAGE_BITS]};
    assign in_index      = in_vpn_wide[INDEX_BITS-1:0];
    assign item_vpn      = va_reg[ADDR_BITS-1:PAGE_BITS];
    assign item_vpn_wide = {{INDEX_BITS{1'b0}}, item_vpn};
    assign item_index    = item_vpn_wide[INDEX_BITS-1:0];

    sdtlb_ram #(
        .DEPTH_BITS (INDEX_BITS),
        .WIDTH      (ROW_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_index),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    sdtlb_update #(
        .TAG_BITS  (TAG_BITS),
        .ADDR_BITS (ADDR_BITS),
        .ROW_BITS  (ROW_BITS)
    ) u_update (
        .ctrl   (ctrl_reg),
        .va     (va_reg),
        .pa     (pa_reg),
        .vpn    (item_vpn),
        .rd_row (mem_rd_data),
        .hit    (upd_hit),
        .addr   (upd_addr),
        .wr_en  (upd_wr_en),
        .wr_row (upd_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            sweep_index_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_index_reg <= sweep_index_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg <= '{cmd: command, kind: access_kind, allowed: fill_allowed};
            va_reg   <= virtual_address;
            pa_reg   <= physical_address;
        end
        hit_reg  <= hit_next;
        addr_reg <= addr_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        sweep_index_next = sweep_index_reg;
        done_next        = 1'b0;
        hit_next         = 1'b0;
        addr_next        = '0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = item_index;
        mem_wr_data      = upd_row;
        unique case (state_reg)
            ST_CLEAR, ST_SWEEP:
            begin
                // write an all-invalid row, advance one index per cycle
                mem_wr_en        = 1'b1;
                mem_wr_addr      = sweep_index_reg;
                mem_wr_data      = '0;
                sweep_index_next = sweep_index_reg + 1'b1;
                if (&sweep_index_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = state_reg == ST_SWEEP;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_FLUSH && virtual_address == '0)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                mem_wr_en  = upd_wr_en;
                done_next  = 1'b1;
                hit_next   = upd_hit;
                addr_next  = upd_addr;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done               = done_reg;
    assign hit                = hit_reg;
    assign translated_address = addr_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_SWEEP))
        else $error("result transfer without a finished command");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted command");

    a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> $past(ctrl_reg.cmd) == CMD_LOOKUP)
        else $error("hit reported for a command other than lookup");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mem_wr_en)
        else $error("memory written while idle");

endmodule

@@ tb/sv/split_direct_mapped_tlb_test.sv @@
// Self-checking testbench for the split read/write/fetch direct-mapped TLB.
`timescale 1ns / 1ps

module split_direct_mapped_tlb_test;
    import sdtlb_pkg::*;

    localparam int INDEX_BITS = 12;
    localparam int PAGE_BITS  = 12;
    localparam int ADDR_BITS  = 64;
    localparam int VPN_BITS   = ADDR_BITS - PAGE_BITS;
    localparam int TABLE_SIZE = 1 << INDEX_BITS;

    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam int RANDOM_COMMANDS = 1950;
    localparam int POOL_DEPTH      = 40;
    localparam int STALL_LIMIT     = 25000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PRINT_CAP       = 40;

    typedef struct {
        logic [1:0]           cmd;
        logic [1:0]           kind;
        logic [ADDR_BITS-1:0] va;
        logic [ADDR_BITS-1:0] pa;
        logic                 allowed;
        bit                   drain_first;
    } tlb_cmd_t;

    typedef struct {
        logic                 hit;
        logic [ADDR_BITS-1:0] addr;
        logic [1:0]           cmd;
        logic [ADDR_BITS-1:0] va;
    } tlb_answer_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           command = CMD_LOOKUP;
    logic [1:0]           access_kind = KIND_READ;
    logic [ADDR_BITS-1:0] virtual_address = '0;
    logic [ADDR_BITS-1:0] physical_address = '0;
    logic                 fill_allowed = 1'b0;
    logic                 done;
    logic                 hit;
    logic [ADDR_BITS-1:0] translated_address;

    split_direct_mapped_tlb #(
        .INDEX_BITS(INDEX_BITS),
        .PAGE_BITS (PAGE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .access_kind       (access_kind),
        .virtual_address   (virtual_address),
        .physical_address  (physical_address),
        .fill_allowed      (fill_allowed),
        .done              (done),
        .hit               (hit),
        .translated_address(translated_address)
    );

    always #10 clk = ~clk;

    // Mirror of the three tables
    bit                   tbl_valid  [TABLE_COUNT][TABLE_SIZE];
    logic [VPN_BITS-1:0]  tbl_tag    [TABLE_COUNT][TABLE_SIZE];
    logic [ADDR_BITS-1:0] tbl_offset [TABLE_COUNT][TABLE_SIZE];

    tlb_cmd_t             cmd_queue[$];
    tlb_answer_t          answers_due[$];
    logic [ADDR_BITS-1:0] page_pool[$];

    int mismatches = 0;
    int idle_cycles = 0;
    int n_lookups = 0, n_hits = 0, n_fills = 0, n_flushes = 0, n_sweeps = 0, n_other = 0;
    bit xfer_seen = 1'b0;

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Apply one command to the mirror tables and return the answer it gives
    function automatic tlb_answer_t apply_tlb_command(input tlb_cmd_t r);
        tlb_answer_t         a;
        logic [VPN_BITS-1:0] vpn;
        int                  slot;
        a.hit  = 1'b0;
        a.addr = '0;
        a.cmd  = r.cmd;
        a.va   = r.va;
        vpn  = r.va[ADDR_BITS-1:PAGE_BITS];
        slot = int'(vpn[INDEX_BITS-1:0]);
        case (r.cmd)
            CMD_LOOKUP: begin
                if (r.kind != KIND_UNKNOWN && tbl_valid[r.kind][slot]
                        && tbl_tag[r.kind][slot] == vpn) begin
                    a.hit  = 1'b1;
                    a.addr = tbl_offset[r.kind][slot] + r.va;
                end
            end
            CMD_FILL: begin
                if (r.kind != KIND_UNKNOWN && r.allowed) begin
                    tbl_offset[r.kind][slot] = r.pa - r.va;
                    tbl_tag[r.kind][slot]    = vpn;
                    tbl_valid[r.kind][slot]  = 1'b1;
                end
            end
            CMD_FLUSH: begin
                for (int t = 0; t < TABLE_COUNT; t++) begin
                    if (r.va == '0) begin
                        for (int i = 0; i < TABLE_SIZE; i++)
                            tbl_valid[t][i] = 1'b0;
                    end else if (tbl_valid[t][slot] && tbl_tag[t][slot] == vpn) begin
                        tbl_valid[t][slot] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Mostly reuse known pages so lookups and flushes find something
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] base;
        int                   roll;
        roll = $urandom_range(0, 9);
        if (page_pool.size() == 0 || roll == 0)
            return rand_addr();
        base = page_pool[$urandom_range(0, page_pool.size() - 1)];
        base[PAGE_BITS-1:0] = PAGE_BITS'($urandom);
        // same index, different tag
        if (roll == 1)
            base ^= ADDR_BITS'($urandom_range(1, 255)) << (PAGE_BITS + INDEX_BITS);
        return base;
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input logic [1:0] kind,
                             input logic [ADDR_BITS-1:0] va,
                             input logic [ADDR_BITS-1:0] pa,
                             input logic allowed, input bit drain_first);
        tlb_cmd_t r;
        r.cmd         = cmd;
        r.kind        = kind;
        r.va          = va;
        r.pa          = pa;
        r.allowed     = allowed;
        r.drain_first = drain_first;
        cmd_queue.push_back(r);
    endtask

    task automatic queue_random_cmds(input int count);
        tlb_cmd_t r;
        int       choice;
        for (int n = 0; n < count; n++) begin
            choice        = $urandom_range(0, 999);
            r.kind        = ($urandom_range(0, 19) == 0) ? KIND_UNKNOWN
                                                         : 2'($urandom_range(0, 2));
            r.pa          = rand_addr();
            r.allowed     = $urandom_range(0, 7) != 0;
            r.va          = pick_address();
            r.drain_first = $urandom_range(0, 149) == 0;
            if (choice < 4) begin
                r.cmd = CMD_FLUSH;
                r.va  = '0;
            end else if (choice < 30) begin
                r.cmd = CMD_UNKNOWN;
            end else if (choice < 100) begin
                r.cmd = CMD_FLUSH;
            end else if (choice < 400) begin
                r.cmd = CMD_FILL;
                if ($urandom_range(0, 1) == 0) begin
                    r.va = rand_addr();
                    page_pool.push_back(r.va);
                    if (page_pool.size() > POOL_DEPTH)
                        void'(page_pool.pop_front());
                end
            end else begin
                r.cmd = CMD_LOOKUP;
            end
            cmd_queue.push_back(r);
        end
    endtask

    // Driver: present one command at a time, in bursts separated by gaps
    tlb_cmd_t cur_cmd = '{default: '0};
    bit       holding = 1'b0;
    int       burst_left = 1;
    int       gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (xfer_seen)
                holding = 1'b0;
            if (!holding)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() != 0
                         && !(cmd_queue[0].drain_first && answers_due.size() != 0))
                begin
                    cur_cmd = cmd_queue.pop_front();
                    holding = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(40, 160);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 9);
                        end
                    end
                end
            end
        end
        start            <= holding;
        command          <= cur_cmd.cmd;
        access_kind      <= cur_cmd.kind;
        virtual_address  <= cur_cmd.va;
        physical_address <= cur_cmd.pa;
        fill_allowed     <= cur_cmd.allowed;
    end

    // Monitor: check each result against the oldest answer due, then log transfers
    always @(posedge clk)
    begin
        tlb_answer_t due;
        tlb_cmd_t    req;
        bit          xfer;
        xfer = rst_n && start && !busy;
        if (rst_n)
        begin
            if (done !== 1'b0)
            begin
                if (answers_due.size() == 0)
                    flag_mismatch($sformatf("result hit=%b addr=%h with nothing outstanding",
                                            hit, translated_address));
                else
                begin
                    due = answers_due.pop_front();
                    if (hit !== due.hit || translated_address !== due.addr)
                        flag_mismatch($sformatf(
                            "cmd %0d va %h: hit=%b addr=%h, want hit=%b addr=%h",
                            due.cmd, due.va, hit, translated_address, due.hit, due.addr));
                end
            end
            if (xfer)
            begin
                req.cmd         = command;
                req.kind        = access_kind;
                req.va          = virtual_address;
                req.pa          = physical_address;
                req.allowed     = fill_allowed;
                req.drain_first = 1'b0;
                due = apply_tlb_command(req);
                answers_due.push_back(due);
                case (command)
                    CMD_LOOKUP: begin
                        n_lookups++;
                        if (due.hit)
                            n_hits++;
                    end
                    CMD_FILL:  n_fills++;
                    CMD_FLUSH: begin
                        n_flushes++;
                        if (virtual_address == '0)
                            n_sweeps++;
                    end
                    default:   n_other++;
                endcase
            end
        end
        xfer_seen   <= xfer;
        idle_cycles <= (xfer || done === 1'b1) ? 0 : idle_cycles + 1;
    end

    initial
    begin
        logic [ADDR_BITS-1:0] va_a;
        logic [ADDR_BITS-1:0] va_alias;
        va_a     = 64'h0000_7fff_1234_5678;
        va_alias = va_a ^ 64'h1000_0000_0000_0000;

        // empty table, then per-table separation and refused fill
        queue_cmd(CMD_LOOKUP, KIND_READ,  va_a, '0, 1'b1, 1'b0);
        queue_cmd(CMD_FILL,   KIND_READ,  va_a, 64'h0000_0000_8abc_d000, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_READ,  va_a ^ 64'hfff, '0, 1'b0, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_WRITE, va_a, '0, 1'b1, 1'b0);
        queue_cmd(CMD_FILL,   KIND_WRITE, va_a, 64'h0000_0001_0000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_WRITE, va_a, '0, 1'b1, 1'b0);
        queue_cmd(CMD_FILL,   KIND_FETCH, va_a, 64'h8000_0000_0040_0000, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_FETCH, va_a, '0, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_READ,  va_alias, '0, 1'b1, 1'b0);
        // address extremes with wraparound of the sum
        queue_cmd(CMD_FILL,   KIND_READ,  '1, '0, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_READ,  '1, '0, 1'b1, 1'b0);
        queue_cmd(CMD_FILL,   KIND_FETCH, '0, '1, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_FETCH, 64'hfff, '1, 1'b1, 1'b0);
        // unknown table and unknown command
        queue_cmd(CMD_FILL,    KIND_UNKNOWN, va_a, '1, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP,  KIND_UNKNOWN, va_a, '0, 1'b1, 1'b0);
        queue_cmd(CMD_UNKNOWN, KIND_READ,    va_a, '1, 1'b1, 1'b0);
        // single-page flush: tag mismatch keeps the entry, a match clears that page in every table
        queue_cmd(CMD_FLUSH,  KIND_READ,    va_alias, '0, 1'b0, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_READ,    va_a, '0, 1'b0, 1'b0);
        queue_cmd(CMD_FLUSH,  KIND_UNKNOWN, va_a, '0, 1'b1, 1'b1);
        queue_cmd(CMD_LOOKUP, KIND_READ,    va_a, '0, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_FETCH,   va_a, '0, 1'b1, 1'b0);
        // flush all, then the wrap entries must be gone
        queue_cmd(CMD_FLUSH,  KIND_WRITE, '0, '1, 1'b1, 1'b0);
        queue_cmd(CMD_LOOKUP, KIND_READ,  '1, '0, 1'b1, 1'b1);
        queue_cmd(CMD_LOOKUP, KIND_FETCH, 64'hfff, '0, 1'b1, 1'b0);

        page_pool.push_back(va_a);
        queue_random_cmds(RANDOM_COMMANDS);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (cmd_queue.size() != 0 || holding)
            @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d lookups (%0d hits), %0d fills, %0d flushes (%0d full sweeps),",
                 n_lookups, n_hits, n_fills, n_flushes, n_sweeps);
        $display("%0d unknown commands; %0d mismatching results.", n_other, mismatches);
        if (mismatches == 0)
            $display("split_direct_mapped_tlb verification clean");
        else
            $display("split_direct_mapped_tlb verification failed");
        $finish;
    end

    // Watchdog: stop when neither a transfer nor a result is seen for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("split_direct_mapped_tlb verification failed");
        $finish;
    end

endmodule
